// File: design/tnvt_pkg.sv
// package for the top-n value tracker: entry record, cell control group,
// register indexes, action codes and defaults. no dependencies.
package tnvt_pkg;

	localparam int DEF_MAX_ENTRIES = 16;
	localparam logic [4:0] LIST_SIZE_RST = 5'd16;

	// configuration register indexes
	localparam logic [0:0] CFG_KEEP_SMALLEST = 1'b0;
	localparam logic [0:0] CFG_LIST_SIZE = 1'b1;

	// input action codes
	localparam logic ACT_OFFER = 1'b0;
	localparam logic ACT_READ = 1'b1;

	typedef struct packed {
		logic signed [31:0] value;
		logic [30:0] element;
		logic signed [31:0] part;
		logic [15:0] step;
		logic signed [31:0] stime;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic shift_up;
		logic keep_smallest;
		logic not_full;
	} cell_ctl_t;

endpackage

// File: design/top_n_value_tracker_top.sv
// top level of the top-n value tracker: cell chain, fill count, readout
// sequencer and output register. uses tnvt_pkg and tnvt_cell.
// an offered sample enters the cell chain on acceptance; one transaction per cycle while
// s_tready is high. a readout of n entries gives n results (one if empty), one per cycle
// while m_tready is high, loaded into the output register once in the read state; s_tready
// is low until the last result is loaded. the rate is set by the cell chain shifting up.
// reset clears fill count, registers and state; cell contents are kept.
module top_n_value_tracker_top import tnvt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	// input stream
	input logic s_tvalid,
	output logic s_tready,
	input logic [143:0] s_tdata, // sample_value, elem_id, part_id, step_index, sample_time
	input logic [0:0] s_tuser, // action
	// result stream
	output logic m_tvalid,
	input logic m_tready,
	output logic [151:0] m_tdata, // rank, best_value, best_element, best_part, best_step, best_time
	output logic [0:0] m_tuser, // entry_valid
	output logic m_tlast,
	// configuration writes
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [4:0] cfg_data
);

	localparam int UW = $clog2(MAX_ENTRIES + 1);
	localparam int LW = (UW > 5) ? UW : 5;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	// configuration registers
	logic keep_smallest_q;
	logic [4:0] list_size_q;

	logic state_q;
	logic [UW-1:0] used_q;
	logic [UW-1:0] rd_cnt_q;
	logic [UW-1:0] rd_total_q;

	logic m_tvalid_q;
	logic [151:0] m_tdata_q;
	logic m_tuser_q;
	logic m_tlast_q;

	logic [LW-1:0] size_ext;
	logic [UW-1:0] cap;
	logic [UW-1:0] used_eff;
	logic s_fire;
	logic offer_fire;
	logic read_fire;
	logic out_load;
	logic rd_last;
	entry_t sample;
	cell_ctl_t ctl;
	entry_t cells [MAX_ENTRIES];
	logic [MAX_ENTRIES:0] taken;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_smallest_q <= 1'b0;
			list_size_q <= LIST_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEEP_SMALLEST: begin
					keep_smallest_q <= cfg_data[0];
				end
				CFG_LIST_SIZE: begin
					list_size_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// effective capacity and fill count after dropping entries beyond it
	assign size_ext = LW'(list_size_q);
	assign cap = (size_ext > LW'(MAX_ENTRIES)) ? UW'(MAX_ENTRIES) : UW'(size_ext);
	assign used_eff = (used_q > cap) ? cap : used_q;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire = s_tvalid & s_tready;
	assign offer_fire = s_fire & (s_tuser[0] == ACT_OFFER);
	assign read_fire = s_fire & (s_tuser[0] == ACT_READ);

	assign sample.value = s_tdata[31:0];
	assign sample.element = s_tdata[62:32];
	assign sample.part = s_tdata[94:63];
	assign sample.step = s_tdata[110:95];
	assign sample.stime = s_tdata[142:111];

	// output slot free or being emptied this cycle
	assign out_load = (state_q == ST_READ) & (~m_tvalid_q | m_tready);
	assign rd_last = (rd_cnt_q == rd_total_q - UW'(1));

	assign ctl.insert = offer_fire;
	assign ctl.shift_up = out_load & (rd_total_q != '0);
	assign ctl.keep_smallest = keep_smallest_q;
	assign ctl.not_full = used_eff < cap;

	// cell chain: rank 0 at index 0, insertion shifts toward the tail,
	// readout shifts toward index 0
	assign taken[0] = 1'b0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		if (i == 0) begin : g_head
			assign prev_e = sample;
		end else begin : g_mid_prev
			assign prev_e = cells[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign next_e = sample;
		end else begin : g_mid_next
			assign next_e = cells[i+1];
		end
		tnvt_cell #(
			.MAX_ENTRIES(MAX_ENTRIES),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.used_eff(used_eff),
			.sample(sample),
			.prev_entry(prev_e),
			.next_entry(next_e),
			.taken_in(taken[i]),
			.taken_out(taken[i+1]),
			.entry(cells[i])
		);
	end

	// fill count and readout sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			rd_cnt_q <= '0;
			rd_total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (offer_fire) begin
						used_q <= ctl.not_full ? used_eff + UW'(1) : used_eff;
					end else if (read_fire) begin
						rd_total_q <= used_q;
						rd_cnt_q <= '0;
						used_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (out_load) begin
						rd_cnt_q <= rd_cnt_q + UW'(1);
						if (rd_total_q == '0 || rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (rd_total_q == '0) begin
				// empty list: one invalid result, all fields zero
				m_tdata_q <= '0;
				m_tuser_q <= 1'b0;
				m_tlast_q <= 1'b1;
			end else begin
				m_tdata_q <= {3'b000, cells[0].stime, cells[0].step, cells[0].part,
					cells[0].element, cells[0].value, 6'(rd_cnt_q)};
				m_tuser_q <= 1'b1;
				m_tlast_q <= rd_last;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign m_tlast = m_tlast_q;

endmodule

// File: design/tnvt_cell.sv
// one cell of the sorted list: holds a single entry, compares the offered
// sample with it and shifts with its neighbors. uses tnvt_pkg.
module tnvt_cell import tnvt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int IDX = 0,
	localparam int UW = $clog2(MAX_ENTRIES + 1)
) (
	input logic clk,
	input cell_ctl_t ctl,
	input logic [UW-1:0] used_eff,
	input entry_t sample,
	input entry_t prev_entry,
	input entry_t next_entry,
	input logic taken_in,
	output logic taken_out,
	output entry_t entry
);

	entry_t entry_q;
	logic in_range;
	logic beat;
	logic at_tail;
	logic take_sample;
	logic take_prev;

	assign in_range = UW'(IDX) < used_eff;
	assign beat = in_range & (ctl.keep_smallest ? (sample.value < entry_q.value)
		: (sample.value > entry_q.value));
	assign at_tail = (UW'(IDX) == used_eff) & ctl.not_full;
	assign taken_out = taken_in | beat;
	// first beaten entry, or the free slot after the last one
	assign take_sample = ctl.insert & ~taken_in & (beat | at_tail);
	assign take_prev = ctl.insert & taken_in;

	always_ff @(posedge clk) begin
		if (take_sample) begin
			entry_q <= sample;
		end else if (take_prev) begin
			entry_q <= prev_entry;
		end else if (ctl.shift_up) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule
